// ===== rtl/core/bsc_pkg.sv =====
//------------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometric sensor compensation pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_SENSITIVITY = 3'd5;

  // temperature in 0.01 degC: reference point and the low-temperature knee
  localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;
  localparam logic signed [17:0] TEMP_LOW_DELTA = 18'sd3500;
  localparam logic signed [17:0] TEMP_LOW_KNEE  = -18'sd3500;

  localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
  localparam logic signed [30:0] PRES_MIN = 31'sd1000;
  localparam logic signed [30:0] PRES_MAX = 31'sd120000;

  typedef struct packed {
    logic [23:0] pressure_raw;
    logic [23:0] temperature_raw;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_pa;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_sensitivity;
  } coef_t;

endpackage

`default_nettype wire

// ===== rtl/core/baro_sensor_compensation.sv =====
//------------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order temperature compensation of raw barometer conversions.
//
// Input channel in_*: one request carries a raw pressure and a raw temperature
// conversion. Result channel out_*: one request per input with temperature in
// 0.01 degC, pressure in Pa and a flag set when either value was clamped.
// Configuration channel cfg_*: writes one of six 16-bit factory coefficients
// by index; always ready. Indexes past the last coefficient are dropped.
// Write coefficients only while no request is in flight.
// Each accepted request passes through the ten register stages of the
// datapath (two multiplier levels, the D1 * SENS product split over two
// stages, then shifts and clamps) on its way to the result.
// Throughput is one request per cycle. When the receiver stalls, the stages
// behind the result hold; empty stages keep filling, so in_ready stays high
// until every stage is occupied.
// Reset clears all valid bits and zeroes the coefficients.
//------------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire bsc_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bsc_pkg::out_t                        out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsc_pkg::*;

  coef_t coef_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESSURE_SENSITIVITY:    coef_r.pressure_sensitivity    <= cfg_data;
        REG_PRESSURE_OFFSET:         coef_r.pressure_offset         <= cfg_data;
        REG_SENSITIVITY_TEMP_COEFF:  coef_r.sensitivity_temp_coeff  <= cfg_data;
        REG_OFFSET_TEMP_COEFF:       coef_r.offset_temp_coeff       <= cfg_data;
        REG_REFERENCE_TEMPERATURE:   coef_r.reference_temperature   <= cfg_data;
        REG_TEMPERATURE_SENSITIVITY: coef_r.temperature_sensitivity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bsc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the sink is ready");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressure_pa >= 17'd1000 && out_data.pressure_pa <= 17'd120000
                   && out_data.temperature_centi >= -15'sd4000
                   && out_data.temperature_centi <= 15'sd8500))
    else $error("result outside clamp range");

  a_coef_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_REFERENCE_TEMPERATURE)
      |=> coef_r.reference_temperature == $past(cfg_data))
    else $error("coefficient write lost");

endmodule

`default_nettype wire

// ===== rtl/core/bsc_pipe.sv =====
//------------------------------------------------------------------------------
// bsc_pipe
// Ten-stage compensation datapath with per-stage valid bits and stall logic.
//------------------------------------------------------------------------------
`default_nettype none

module bsc_pipe (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bsc_pkg::coef_t coef,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bsc_pkg::out_t      out_data
);
  import bsc_pkg::*;

  localparam int NST = 10;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  // a stage loads when it or any later stage holds a bubble, or the sink takes
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[NST-1:k]);
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: dT
  logic [23:0]        d1_1_r;
  logic signed [24:0] dt_1_r;
  logic signed [24:0] dt_nxt;

  assign dt_nxt = $signed({1'b0, in_data.temperature_raw})
                - $signed({1'b0, coef.reference_temperature, 8'b0});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_1_r <= in_data.pressure_raw;
      dt_1_r <= dt_nxt;
    end
  end

  // stage 2: first-order products and dT squared
  logic [23:0]        d1_2_r;
  logic signed [41:0] dtc6_2_r, offm_2_r, sensm_2_r;
  logic [47:0]        dtsq_2_r;
  logic signed [49:0] dtsq_nxt;

  assign dtsq_nxt = dt_1_r * dt_1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_2_r    <= d1_1_r;
      dtc6_2_r  <= dt_1_r * $signed({1'b0, coef.temperature_sensitivity});
      offm_2_r  <= dt_1_r * $signed({1'b0, coef.offset_temp_coeff});
      sensm_2_r <= dt_1_r * $signed({1'b0, coef.sensitivity_temp_coeff});
      dtsq_2_r  <= dtsq_nxt[47:0];
    end
  end

  // stage 3: TEMP offset, OFF, SENS, T2 and the low-temperature tests
  logic [23:0]        d1_3_r;
  logic signed [17:0] a_3_r, b_3_r;
  logic               lt2000_3_r;
  logic signed [40:0] off1_3_r, sens1_3_r;
  logic [16:0]        t2_3_r;
  logic signed [17:0] a_nxt;
  logic               lt1500_nxt;

  assign a_nxt      = dtc6_2_r[40:23];
  assign lt1500_nxt = a_nxt < TEMP_LOW_KNEE;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_3_r     <= d1_2_r;
      a_3_r      <= a_nxt;
      b_3_r      <= lt1500_nxt ? (a_nxt + TEMP_LOW_DELTA) : '0;
      lt2000_3_r <= dtc6_2_r[41];
      off1_3_r   <= $signed({9'b0, coef.pressure_offset, 16'b0})
                  + $signed(offm_2_r[41:7]);
      sens1_3_r  <= $signed({10'b0, coef.pressure_sensitivity, 15'b0})
                  + $signed(sensm_2_r[41:8]);
      t2_3_r     <= dtsq_2_r[47:31];
    end
  end

  // stage 4: squares, final temperature and its clamp
  logic [23:0]        d1_4_r;
  logic [34:0]        asq_4_r, bsq_4_r;
  logic               lt2000_4_r;
  logic signed [40:0] off1_4_r, sens1_4_r;
  logic signed [14:0] temp_4_r;
  logic               tsat_4_r;
  logic signed [35:0] asq_nxt, bsq_nxt;
  logic [16:0]        t2_g;
  logic signed [19:0] tf;

  assign asq_nxt = a_3_r * a_3_r;
  assign bsq_nxt = b_3_r * b_3_r;
  assign t2_g    = lt2000_3_r ? t2_3_r : '0;
  assign tf      = $signed({{2{a_3_r[17]}}, a_3_r}) + TEMP_REF_CENTI
                 - $signed({3'b0, t2_g});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_4_r     <= d1_3_r;
      asq_4_r    <= asq_nxt[34:0];
      bsq_4_r    <= bsq_nxt[34:0];
      lt2000_4_r <= lt2000_3_r;
      off1_4_r   <= off1_3_r;
      sens1_4_r  <= sens1_3_r;
      if (tf < TEMP_MIN) begin
        temp_4_r <= TEMP_MIN[14:0];
        tsat_4_r <= 1'b1;
      end else if (tf > TEMP_MAX) begin
        temp_4_r <= TEMP_MAX[14:0];
        tsat_4_r <= 1'b1;
      end else begin
        temp_4_r <= tf[14:0];
        tsat_4_r <= 1'b0;
      end
    end
  end

  // stage 5: OFF2 and SENS2
  logic [23:0]        d1_5_r;
  logic signed [40:0] off1_5_r, sens1_5_r;
  logic [37:0]        off2_5_r, sens2_5_r;
  logic signed [14:0] temp_5_r;
  logic               tsat_5_r;
  logic [36:0]        sq5;
  logic [37:0]        b7, b11;

  assign sq5 = {2'b0, asq_4_r} + {asq_4_r, 2'b0};
  assign b7  = {bsq_4_r, 3'b0} - {3'b0, bsq_4_r};
  assign b11 = {bsq_4_r, 3'b0} + {2'b0, bsq_4_r, 1'b0} + {3'b0, bsq_4_r};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_5_r    <= d1_4_r;
      off1_5_r  <= off1_4_r;
      sens1_5_r <= sens1_4_r;
      off2_5_r  <= lt2000_4_r ? ({2'b0, sq5[36:1]} + b7) : '0;
      sens2_5_r <= lt2000_4_r ? ({3'b0, sq5[36:2]} + {1'b0, b11[37:1]}) : '0;
      temp_5_r  <= temp_4_r;
      tsat_5_r  <= tsat_4_r;
    end
  end

  // stage 6: corrected OFF and SENS
  logic [23:0]        d1_6_r;
  logic signed [40:0] off_6_r, sens_6_r;
  logic signed [14:0] temp_6_r;
  logic               tsat_6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d1_6_r   <= d1_5_r;
      off_6_r  <= off1_5_r - $signed({3'b0, off2_5_r});
      sens_6_r <= sens1_5_r - $signed({3'b0, sens2_5_r});
      temp_6_r <= temp_5_r;
      tsat_6_r <= tsat_5_r;
    end
  end

  // stage 7: D1 * SENS as two partial products
  logic [43:0]        pplo_7_r;
  logic signed [45:0] pphi_7_r;
  logic signed [40:0] off_7_r;
  logic signed [14:0] temp_7_r;
  logic               tsat_7_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      pplo_7_r <= d1_6_r * sens_6_r[19:0];
      pphi_7_r <= $signed({1'b0, d1_6_r}) * $signed(sens_6_r[40:20]);
      off_7_r  <= off_6_r;
      temp_7_r <= temp_6_r;
      tsat_7_r <= tsat_6_r;
    end
  end

  // stage 8: merge partial products, floor shift by 21
  logic signed [44:0] shf_8_r;
  logic signed [40:0] off_8_r;
  logic signed [14:0] temp_8_r;
  logic               tsat_8_r;
  logic signed [65:0] prod;

  assign prod = $signed({pphi_7_r, 20'b0}) + $signed({22'b0, pplo_7_r});

  always_ff @(posedge clk) begin
    if (en[7]) begin
      shf_8_r  <= prod[65:21];
      off_8_r  <= off_7_r;
      temp_8_r <= temp_7_r;
      tsat_8_r <= tsat_7_r;
    end
  end

  // stage 9: subtract OFF
  logic signed [45:0] pdiff_9_r;
  logic signed [14:0] temp_9_r;
  logic               tsat_9_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pdiff_9_r <= $signed({shf_8_r[44], shf_8_r}) - $signed({{5{off_8_r[40]}}, off_8_r});
      temp_9_r  <= temp_8_r;
      tsat_9_r  <= tsat_8_r;
    end
  end

  // stage 10: floor shift by 15, clamp pressure, output register
  logic signed [30:0] pres;
  out_t               out_r;

  assign pres = pdiff_9_r[45:15];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      out_r.temperature_centi <= temp_9_r;
      if (pres < PRES_MIN) begin
        out_r.pressure_pa <= PRES_MIN[16:0];
        out_r.saturated   <= 1'b1;
      end else if (pres > PRES_MAX) begin
        out_r.pressure_pa <= PRES_MAX[16:0];
        out_r.saturated   <= 1'b1;
      end else begin
        out_r.pressure_pa <= pres[16:0];
        out_r.saturated   <= tsat_9_r;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== dv/baro_compensation_checker.sv =====
//------------------------------------------------------------------------------
// baro_compensation_checker
// Watches the request, result and coefficient channels of the barometric
// compensation block. Keeps its own coefficient copy, computes the
// compensated temperature and pressure of every accepted request in 64-bit
// signed arithmetic and compares each result field with the oldest prediction.
//------------------------------------------------------------------------------
module baro_compensation_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  bsc_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  bsc_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             outstanding,
  output int                             mismatch_count
);
  import bsc_pkg::*;

  localparam longint TEMP_REF  = 2000;
  localparam longint TEMP_KNEE = -1500;
  localparam longint TEMP_LO   = -4000;
  localparam longint TEMP_HI   = 8500;
  localparam longint PRES_LO   = 1000;
  localparam longint PRES_HI   = 120000;

  coef_t coef_copy;
  out_t  pending_compensations[$];
  out_t  want;

  function automatic out_t compensate_reading(in_t req, coef_t c);
    longint d1, d2, dt, temp, off, sens, t2, off2, sens2, pres, a, b, sq5, sq;
    logic   hit;
    out_t   r;
    d1 = longint'(req.pressure_raw);
    d2 = longint'(req.temperature_raw);
    dt = d2 - longint'(c.reference_temperature) * 256;
    temp = TEMP_REF + ((dt * longint'(c.temperature_sensitivity)) >>> 23);
    off = longint'(c.pressure_offset) * 65536
          + ((longint'(c.offset_temp_coeff) * dt) >>> 7);
    sens = longint'(c.pressure_sensitivity) * 32768
           + ((longint'(c.sensitivity_temp_coeff) * dt) >>> 8);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    if (temp < TEMP_REF) begin
      a = temp - TEMP_REF;
      sq5 = 5 * a * a;
      t2 = (dt * dt) >>> 31;
      off2 = sq5 >>> 1;
      sens2 = sq5 >>> 2;
      if (temp < TEMP_KNEE) begin
        b = temp - TEMP_KNEE;
        sq = b * b;
        off2 = off2 + 7 * sq;
        sens2 = sens2 + ((11 * sq) >>> 1);
      end
    end
    temp = temp - t2;
    off = off - off2;
    sens = sens - sens2;
    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    hit = 1'b0;
    if (temp < TEMP_LO) begin
      temp = TEMP_LO;
      hit = 1'b1;
    end else if (temp > TEMP_HI) begin
      temp = TEMP_HI;
      hit = 1'b1;
    end
    if (pres < PRES_LO) begin
      pres = PRES_LO;
      hit = 1'b1;
    end else if (pres > PRES_HI) begin
      pres = PRES_HI;
      hit = 1'b1;
    end
    r.temperature_centi = temp[14:0];
    r.pressure_pa = pres[16:0];
    r.saturated = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      coef_copy <= '0;
      pending_compensations.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_compensations.push_back(compensate_reading(in_data, coef_copy));
      end
      if (out_valid && out_ready) begin
        if (pending_compensations.size() == 0) begin
          $display("%0t: unexpected result temp %0d pres %0d sat %0b", $time,
                   out_data.temperature_centi, out_data.pressure_pa, out_data.saturated);
          mismatch_count++;
        end else begin
          want = pending_compensations.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi) begin
            $display("%0t: temperature_centi expected %0d actual %0d", $time,
                     want.temperature_centi, out_data.temperature_centi);
            mismatch_count++;
          end
          if (out_data.pressure_pa !== want.pressure_pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     want.pressure_pa, out_data.pressure_pa);
            mismatch_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     want.saturated, out_data.saturated);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESSURE_SENSITIVITY:    coef_copy.pressure_sensitivity <= cfg_data;
          REG_PRESSURE_OFFSET:         coef_copy.pressure_offset <= cfg_data;
          REG_SENSITIVITY_TEMP_COEFF:  coef_copy.sensitivity_temp_coeff <= cfg_data;
          REG_OFFSET_TEMP_COEFF:       coef_copy.offset_temp_coeff <= cfg_data;
          REG_REFERENCE_TEMPERATURE:   coef_copy.reference_temperature <= cfg_data;
          REG_TEMPERATURE_SENSITIVITY: coef_copy.temperature_sensitivity <= cfg_data;
          default: ;
        endcase
      end
      outstanding <= pending_compensations.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
//------------------------------------------------------------------------------
// tb
// Drives raw pressure and temperature conversions and factory coefficient
// sets into the barometric compensation block: a short directed set of corner
// readings, then random phases over several coefficient sets with request
// gaps, result stalls and a long result hold-off. The checker beside the
// block predicts and compares; this module reports the verdict.
//------------------------------------------------------------------------------
module tb;
  import bsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int BURST_ITEMS    = 60;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam coef_t TYPICAL_COEFS = '{16'd40127, 16'd36924, 16'd23317,
                                      16'd23282, 16'd33464, 16'd28312};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   outstanding;
  int   mismatch_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic stall_req = 1'b0;
  logic stall_seen = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  always #1 clk = ~clk;

  baro_sensor_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  baro_compensation_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  // result side: random stalls, plus a long hold-off on each toggle of stall_req
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("baro_sensor_compensation verification failed");
        $finish;
      end
    end
  end

  task automatic send_reading(logic [23:0] d1, logic [23:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.pressure_raw <= d1;
    in_data.temperature_raw <= d2;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coefs(coef_t c);
    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom()));
    write_reg(REG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
    write_reg(REG_PRESSURE_OFFSET, c.pressure_offset);
    write_reg(REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
    write_reg(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
    write_reg(REG_REFERENCE_TEMPERATURE, c.reference_temperature);
    write_reg(REG_TEMPERATURE_SENSITIVITY, c.temperature_sensitivity);
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] corner_raw();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 24'd1 << $urandom_range(23);
      default: return ~(24'd1 << $urandom_range(23));
    endcase
  endfunction

  // mostly plausible readings centered on the reference temperature
  function automatic in_t random_reading(coef_t c);
    int unsigned kind;
    longint      d2;
    in_t         r;
    kind = $urandom_range(99);
    if (kind < 20) begin
      r.pressure_raw = 24'($urandom());
      r.temperature_raw = 24'($urandom());
    end else if (kind < 30) begin
      r.pressure_raw = corner_raw();
      r.temperature_raw = corner_raw();
    end else begin
      d2 = longint'(c.reference_temperature) * 256
           + longint'($urandom_range(5000000)) - 2500000;
      if (d2 < 0) d2 = 0;
      if (d2 > 64'hFFFFFF) d2 = 64'hFFFFFF;
      r.pressure_raw = 24'($urandom_range(12000000, 4000000));
      r.temperature_raw = d2[23:0];
    end
    return r;
  endfunction

  initial begin
    in_t   r;
    coef_t c;
    int    p;
    int    n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // coefficients still at reset
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'd9085466, 24'd8569150);
    drain_results();

    load_coefs(TYPICAL_COEFS);
    send_reading(24'd9085466, 24'd8569150);
    send_reading(24'd0, 24'd8569150);
    send_reading(24'hFFFFFF, 24'd8569150);
    send_reading(24'd9085466, 24'd0);
    send_reading(24'd9085466, 24'hFFFFFF);
    send_reading(24'd9085466, 24'd8566784);
    send_reading(24'd9085466, 24'd8566783);
    send_reading(24'd9085466, 24'd8270487);
    send_reading(24'd9085466, 24'd7529744);
    send_reading(24'd9085466, 24'd7529700);
    send_reading(24'd9085466, 24'd7529800);
    send_reading(24'd9085466, 24'd7085298);
    send_reading(24'd9085466, 24'd6789001);
    send_reading(24'd9085466, 24'd9900121);
    send_reading(24'd9085466, 24'd10522340);
    send_reading(24'd6000000, 24'd8569150);
    send_reading(24'd12000000, 24'd8569150);
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    send_reading(24'd0, 24'hFFFFFF);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: c = TYPICAL_COEFS;
        1: c = '1;
        2: c = '0;
        3: begin
          c = TYPICAL_COEFS;
          c.reference_temperature = '1;
          c.temperature_sensitivity = '1;
        end
        4, 5: c = coef_t'({$urandom(), $urandom(), $urandom()});
        default: c = TYPICAL_COEFS
                     ^ (coef_t'({$urandom(), $urandom(), $urandom()}) & {6{16'h0FFF}});
      endcase
      load_coefs(c);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 71;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct <= 22;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 6) && n == BURST_ITEMS) begin
          // hold results off while requests keep coming, then let all drain
          send_idle_pct = 0;
          stall_req <= ~stall_req;
          repeat (BURST_ITEMS) begin
            r = random_reading(c);
            send_reading(r.pressure_raw, r.temperature_raw);
          end
          drain_results();
          send_idle_pct = (p % 4 == 1) ? 71 : 0;
        end
        r = random_reading(c);
        send_reading(r.pressure_raw, r.temperature_raw);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("baro_sensor_compensation verification clean");
    end else begin
      $display("baro_sensor_compensation verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_pipe.sv
rtl/core/baro_sensor_compensation.sv
dv/baro_compensation_checker.sv
dv/tb.sv
